/* src/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// implication checked on every edge out of reset
`define SFWP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define SFWP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SFWP_ASSERT(lbl, prop, msg)
`define SFWP_NEVER(lbl, cond, msg)

`endif

`endif

/* src/sfwp_pkg.sv */
package sfwp_pkg;

  localparam int MAG_W           = 48;
  localparam int FRAC_W          = 3;
  localparam int MAX_FRAC        = 4;
  localparam int SNAP_IW         = $clog2(MAX_FRAC);
  localparam int FIELD_START     = 2;
  localparam int FIELD_LEN       = 10;
  localparam int FRAME_BYTES_DEF = 16;
  localparam int POW_W           = 14;

  localparam logic [MAG_W-1:0]  MAG_MAX  = 48'd99999999999999;
  localparam logic [MAG_W-1:0]  MAG_LIM  = 48'd9999999999999;
  localparam logic [FRAC_W-1:0] FRAC_RST = 3'd2;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGNED,
    PH_INT,
    PH_FRAC,
    PH_END
  } phase_t;

  typedef struct packed {
    phase_t                           phase;
    logic                             neg;
    logic                             seen;
    logic [FRAC_W-1:0]                fc;
    logic [MAG_W-1:0]                 mag;
    logic [MAX_FRAC-1:0][MAG_W-1:0]   snap;  // magnitude with j fraction digits
  } pst_t;

  typedef struct packed {
    pst_t              st;
    logic [FRAC_W-1:0] fd;   // clamped fraction_digits
  } frame_t;

  localparam pst_t PST_CLR = '{phase: PH_LEAD, neg: 1'b0, seen: 1'b0,
                               fc: '0, mag: '0, snap: '0};

  function automatic logic [POW_W-1:0] pow10(input logic [FRAC_W-1:0] k);
    logic [POW_W-1:0] p;
    case (k)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      3'd4:    p = 14'd10000;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

  // floor(MAG_MAX / 10^k)
  function automatic logic [MAG_W-1:0] mag_max_div(input logic [FRAC_W-1:0] k);
    logic [MAG_W-1:0] m;
    case (k)
      3'd0:    m = MAG_MAX;
      3'd1:    m = 48'd9999999999999;
      3'd2:    m = 48'd999999999999;
      3'd3:    m = 48'd99999999999;
      3'd4:    m = 48'd9999999999;
      default: m = MAG_MAX;
    endcase
    return m;
  endfunction

endpackage

/* src/sfwp_parse.sv */
`include "assert_macros.svh"

module sfwp_parse #(
  parameter int FRAME_BYTES = sfwp_pkg::FRAME_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [sfwp_pkg::FRAC_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_rx_byte,
  output logic                         frm_valid,
  input  logic                         frm_stall,
  output sfwp_pkg::frame_t             frm
);

  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam int CMP_W = 8;

  logic [IDX_W-1:0]             idx_r;
  logic [sfwp_pkg::FRAC_W-1:0]  fd_r;
  sfwp_pkg::pst_t               st_r;
  sfwp_pkg::pst_t               take_nxt;
  sfwp_pkg::pst_t               st_nxt;
  sfwp_pkg::frame_t             frm_r;
  logic                         frm_v_r;

  logic                         in_acc;
  logic                         last;
  logic                         in_field;
  logic                         digit;
  logic                         blank;
  logic                         num;
  logic [3:0]                   dval;
  logic [sfwp_pkg::FRAC_W-1:0]  kept;
  logic [sfwp_pkg::MAG_W-1:0]   mag_ttp;

  assign in_stall  = frm_v_r && frm_stall;
  assign in_acc    = in_valid && !in_stall;
  assign last      = (idx_r == IDX_W'(FRAME_BYTES - 1));
  assign in_field  = (CMP_W'(idx_r) >= CMP_W'(sfwp_pkg::FIELD_START)) &&
                     (CMP_W'(idx_r) < CMP_W'(sfwp_pkg::FIELD_START + sfwp_pkg::FIELD_LEN));
  assign kept      = (fd_r > sfwp_pkg::FRAC_W'(sfwp_pkg::MAX_FRAC)) ?
                     sfwp_pkg::FRAC_W'(sfwp_pkg::MAX_FRAC) : fd_r;
  assign frm_valid = frm_v_r;
  assign frm       = frm_r;

  always_comb begin
    digit   = (in_rx_byte >= sfwp_pkg::CH_ZERO) && (in_rx_byte <= sfwp_pkg::CH_NINE);
    dval    = digit ? in_rx_byte[3:0] : 4'd0;
    blank   = (in_rx_byte == sfwp_pkg::CH_SPACE) ||
              ((in_rx_byte >= sfwp_pkg::CH_TAB) && (in_rx_byte <= sfwp_pkg::CH_CR));
    // saturating m*10+d, the limit is the same for every digit
    mag_ttp = (st_r.mag > sfwp_pkg::MAG_LIM) ? sfwp_pkg::MAG_MAX :
              (st_r.mag << 3) + (st_r.mag << 1) + sfwp_pkg::MAG_W'(dval);
    take_nxt = st_r;
    num      = 1'b0;
    case (st_r.phase)
      sfwp_pkg::PH_LEAD: begin
        if (blank) begin
          take_nxt = st_r;
        end else if (in_rx_byte == sfwp_pkg::CH_PLUS || in_rx_byte == sfwp_pkg::CH_MINUS) begin
          take_nxt.neg   = (in_rx_byte == sfwp_pkg::CH_MINUS);
          take_nxt.phase = sfwp_pkg::PH_SIGNED;
        end else begin
          num = 1'b1;
        end
      end
      sfwp_pkg::PH_SIGNED, sfwp_pkg::PH_INT: begin
        num = 1'b1;
      end
      sfwp_pkg::PH_FRAC: begin
        if (digit) begin
          take_nxt.seen = 1'b1;
          if (st_r.fc < kept) begin
            take_nxt.snap[st_r.fc[sfwp_pkg::SNAP_IW-1:0]] = st_r.mag;
            take_nxt.mag = mag_ttp;
            take_nxt.fc  = st_r.fc + 1'b1;
          end
        end else begin
          take_nxt.phase = sfwp_pkg::PH_END;
        end
      end
      default: begin
        take_nxt = st_r;
      end
    endcase
    if (num) begin
      if (digit) begin
        take_nxt.mag   = mag_ttp;
        take_nxt.seen  = 1'b1;
        take_nxt.phase = sfwp_pkg::PH_INT;
      end else if (in_rx_byte == sfwp_pkg::CH_POINT) begin
        take_nxt.phase = sfwp_pkg::PH_FRAC;
      end else begin
        take_nxt.phase = sfwp_pkg::PH_END;
      end
    end
    st_nxt = in_field ? take_nxt : st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      fd_r    <= sfwp_pkg::FRAC_RST;
      st_r    <= sfwp_pkg::PST_CLR;
      frm_v_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fd_r <= cfg_wr_data;
      end
      if (in_acc && last) begin
        frm_v_r <= 1'b1;
      end else if (!frm_stall) begin
        frm_v_r <= 1'b0;
      end
      if (in_acc) begin
        // newline restarts the frame wherever it lands
        if (last || in_rx_byte == sfwp_pkg::CH_NEWLINE) begin
          idx_r <= '0;
          st_r  <= sfwp_pkg::PST_CLR;
        end else begin
          idx_r <= idx_r + 1'b1;
          st_r  <= st_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last) begin
      frm_r.st <= st_nxt;
      frm_r.fd <= kept;
    end
  end

  `SFWP_ASSERT(a_frm_hold, frm_v_r && frm_stall |=> frm_v_r && $stable(frm_r), "frame beat lost under stall")
  `SFWP_ASSERT(a_fc_seen, st_r.fc != '0 |-> st_r.seen && st_r.fc <= sfwp_pkg::FRAC_W'(sfwp_pkg::MAX_FRAC), "fraction count without digit")
  `SFWP_ASSERT(a_pre_field, CMP_W'(idx_r) <= CMP_W'(sfwp_pkg::FIELD_START) |-> st_r.phase == sfwp_pkg::PH_LEAD && st_r.mag == '0, "parse state moved before field")

endmodule

/* src/sfwp_emit.sv */
`include "assert_macros.svh"

module sfwp_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        frm_valid,
  output logic                        frm_stall,
  input  sfwp_pkg::frame_t            frm,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [sfwp_pkg::MAG_W-1:0] out_weight_scaled,
  output logic                        out_parse_ok
);

  logic                         scl_v_r;
  logic [sfwp_pkg::MAG_W-1:0]   base_r;
  logic [sfwp_pkg::FRAC_W-1:0]  k_r;
  logic                         over_r;
  logic                         neg_r;
  logic                         ok_r;

  logic [sfwp_pkg::MAG_W-1:0]   base_nxt;
  logic [sfwp_pkg::FRAC_W-1:0]  k_nxt;
  logic                         over_nxt;

  logic                         out_v_r;
  logic [sfwp_pkg::MAG_W-1:0]   w_r;
  logic                         ok_out_r;

  logic [sfwp_pkg::MAG_W-1:0]   prod;
  logic [sfwp_pkg::MAG_W-1:0]   mv;
  logic [sfwp_pkg::MAG_W-1:0]   w_nxt;

  logic out_adv;
  logic scl_adv;

  assign out_adv   = !out_v_r || !out_stall;
  assign scl_adv   = !scl_v_r || out_adv;
  assign frm_stall = !scl_adv;

  // pick the value with fd fraction digits, or find how far to scale up
  always_comb begin
    base_nxt = frm.st.mag;
    k_nxt    = '0;
    over_nxt = 1'b0;
    if (frm.st.fc > frm.fd) begin
      // a saturated accumulator truncates to the saturated constant
      base_nxt = (frm.st.mag == sfwp_pkg::MAG_MAX) ?
                 sfwp_pkg::mag_max_div(frm.st.fc - frm.fd) :
                 frm.st.snap[frm.fd[sfwp_pkg::SNAP_IW-1:0]];
    end else if (frm.st.fc < frm.fd) begin
      k_nxt    = frm.fd - frm.st.fc;
      over_nxt = frm.st.mag > sfwp_pkg::mag_max_div(frm.fd - frm.st.fc);
    end
  end

  always_comb begin
    prod  = base_r * sfwp_pkg::MAG_W'(sfwp_pkg::pow10(k_r));
    mv    = over_r ? sfwp_pkg::MAG_MAX : prod;
    w_nxt = !ok_r ? '0 : (neg_r ? (~mv + 1'b1) : mv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (scl_adv) begin
        scl_v_r <= frm_valid;
      end
      if (out_adv) begin
        out_v_r <= scl_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scl_adv && frm_valid) begin
      base_r <= base_nxt;
      k_r    <= k_nxt;
      over_r <= over_nxt;
      neg_r  <= frm.st.neg;
      ok_r   <= frm.st.seen;
    end
    if (out_adv && scl_v_r) begin
      w_r      <= w_nxt;
      ok_out_r <= ok_r;
    end
  end

  assign out_valid         = out_v_r;
  assign out_weight_scaled = $signed(w_r);
  assign out_parse_ok      = ok_out_r;

  `SFWP_ASSERT(a_scl_hold, scl_v_r && !out_adv |=> scl_v_r && $stable(base_r) && $stable(k_r), "scale stage dropped a beat")
  `SFWP_ASSERT(a_nan_zero, out_v_r && !ok_out_r |-> w_r == '0, "not-a-number beat with nonzero weight")
  `SFWP_NEVER(a_range, out_v_r && (out_weight_scaled > $signed(sfwp_pkg::MAG_MAX) || out_weight_scaled < -$signed(sfwp_pkg::MAG_MAX)), "weight out of range")

endmodule

/* src/scale_frame_weight_parser_top.sv */
// one byte beat accepted per cycle, every cycle, while the result side keeps up
// a frame's result reaches the output after the frame register, the scale select
// register and the multiply and sign output register
// sustained rate: one byte per cycle while the result side keeps up, at most one result per FRAME_BYTES bytes
// synchronous active-low reset clears the byte count, parse state and pipeline
// valids, and sets fraction_digits to 2
module scale_frame_weight_parser_top #(
  parameter int FRAME_BYTES = sfwp_pkg::FRAME_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [sfwp_pkg::FRAC_W-1:0]       cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [sfwp_pkg::MAG_W-1:0] out_weight_scaled,
  output logic                              out_parse_ok
);

  logic             frm_valid;
  logic             frm_stall;
  sfwp_pkg::frame_t frm;

  sfwp_parse #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .frm_valid  (frm_valid),
    .frm_stall  (frm_stall),
    .frm        (frm)
  );

  sfwp_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .frm_valid        (frm_valid),
    .frm_stall        (frm_stall),
    .frm              (frm),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_weight_scaled(out_weight_scaled),
    .out_parse_ok     (out_parse_ok)
  );

endmodule

/* tb/testbench.sv */
module testbench;
  import sfwp_pkg::*;

  localparam int FRAME_LEN     = FRAME_BYTES_DEF;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 600000;
  localparam longint unsigned WEIGHT_CAP = 64'd99999999999999;

  typedef struct packed {
    logic [MAG_W-1:0] weight;
    logic             ok;
  } reading_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_wr_en = 1'b0;
  logic [FRAC_W-1:0]       cfg_wr_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [7:0]              in_rx_byte = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [MAG_W-1:0] out_weight_scaled;
  logic                    out_parse_ok;

  scale_frame_weight_parser_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_weight_scaled(out_weight_scaled),
    .out_parse_ok     (out_parse_ok)
  );

  reading_t   readings_due[$];
  logic [7:0] byte_q[$];
  logic [7:0] carry_q[$];
  logic [7:0] field_buf [FIELD_LEN];
  int         field_pos;
  int         queued_count = 0;
  int         accepted_count = 0;
  int         fail_count = 0;
  int         cycle_count = 0;
  bit         beat_taken = 1'b0;
  bit         calm = 1'b0;
  int         send_gap = 0;
  int         stall_left = 0;

  // parser state as the block should hold it
  logic [FRAC_W-1:0] frac_setting = FRAC_RST;
  int                frame_pos;
  phase_t            phase;
  bit                neg_sign;
  bit                any_digit;
  int                frac_kept;
  longint unsigned   digits_mag;

  function automatic int kept_places();
    return (frac_setting > MAX_FRAC) ? MAX_FRAC : int'(frac_setting);
  endfunction

  function automatic longint unsigned mul10_add(input longint unsigned m,
                                                input longint unsigned d);
    if (m > (WEIGHT_CAP - d) / 10) return WEIGHT_CAP;
    return m * 10 + d;
  endfunction

  function automatic void clear_parse();
    frame_pos  = 0;
    phase      = PH_LEAD;
    neg_sign   = 1'b0;
    any_digit  = 1'b0;
    frac_kept  = 0;
    digits_mag = 0;
  endfunction

  function automatic void step_byte(input logic [7:0] c);
    bit              is_digit;
    bit              start_num;
    longint unsigned d;
    longint unsigned m;
    int              fc;
    int              fd;
    reading_t        r;
    is_digit  = (c >= CH_ZERO && c <= CH_NINE);
    d         = is_digit ? 64'(c - CH_ZERO) : 64'd0;
    start_num = 1'b0;
    if (frame_pos >= FIELD_START && frame_pos < FIELD_START + FIELD_LEN) begin
      case (phase)
        PH_LEAD: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            neg_sign = (c == CH_MINUS);
            phase    = PH_SIGNED;
          end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
            start_num = 1'b1;
          end
        end
        PH_SIGNED, PH_INT: start_num = 1'b1;
        PH_FRAC: begin
          if (is_digit) begin
            any_digit = 1'b1;
            if (frac_kept < kept_places()) begin
              digits_mag = mul10_add(digits_mag, d);
              frac_kept++;
            end
          end else begin
            phase = PH_END;
          end
        end
        default: ;
      endcase
      if (start_num) begin
        if (is_digit) begin
          digits_mag = mul10_add(digits_mag, d);
          any_digit  = 1'b1;
          phase      = PH_INT;
        end else if (c == CH_POINT) begin
          phase = PH_FRAC;
        end else begin
          phase = PH_END;
        end
      end
    end
    frame_pos++;
    if (frame_pos >= FRAME_LEN) begin
      if (!any_digit) begin
        r.weight = '0;
        r.ok     = 1'b0;
      end else begin
        m  = digits_mag;
        fc = frac_kept;
        fd = kept_places();
        // fraction digits kept beyond the setting are truncated away
        while (fc > fd) begin
          m = m / 10;
          fc--;
        end
        while (fc < fd) begin
          m = mul10_add(m, 0);
          fc++;
        end
        if (neg_sign) m = -m;
        r.weight = m[MAG_W-1:0];
        r.ok     = 1'b1;
      end
      readings_due.push_back(r);
      clear_parse();
    end
    if (c == CH_NEWLINE) clear_parse();
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == CH_NEWLINE) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send(input logic [7:0] b);
    byte_q.push_back(b);
    queued_count++;
  endtask

  task automatic put_field(input logic [7:0] c);
    if (field_pos < FIELD_LEN) begin
      field_buf[field_pos] = c;
      field_pos++;
    end
  endtask

  task automatic load_field(input string s);
    for (int i = 0; i < FIELD_LEN; i++) begin
      field_buf[i] = (i < s.len()) ? s[i] : CH_SPACE;
    end
  endtask

  // bytes from cut onward are held back for the next phase
  task automatic queue_frame(input logic [7:0] h0, input logic [7:0] h1,
                             input bit nl_end, input int cut);
    logic [7:0] fr [FRAME_LEN];
    fr[0] = h0;
    fr[1] = h1;
    for (int i = 0; i < FIELD_LEN; i++) fr[FIELD_START + i] = field_buf[i];
    for (int i = FIELD_START + FIELD_LEN; i < FRAME_LEN - 1; i++) fr[i] = text_byte();
    fr[FRAME_LEN-1] = nl_end ? CH_NEWLINE : text_byte();
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (i < cut) send(fr[i]);
      else carry_q.push_back(fr[i]);
    end
  endtask

  // broken frame: a newline after p bytes, or sixteen random bytes
  task automatic queue_noise(input int p);
    for (int i = 0; i < p; i++) send(text_byte());
    if (p >= FRAME_LEN - 1) send(text_byte());
    else send(CH_NEWLINE);
  endtask

  task automatic wait_idle();
    while (accepted_count != queued_count || readings_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_fraction(input logic [FRAC_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    frac_setting = v;
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    reading_t want;
    beat_taken = rst_n && in_valid && !in_stall;
    if (!rst_n) begin
      clear_parse();
      frac_setting = FRAC_RST;
    end else begin
      // results come out well after their beat, so check before predicting
      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: weight %0d ok %0b",
                     out_weight_scaled, out_parse_ok);
        end else begin
          want = readings_due.pop_front();
          if (out_weight_scaled !== want.weight || out_parse_ok !== want.ok) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected weight %0d ok %0b, got weight %0d ok %0b",
                       $signed(want.weight), want.ok, out_weight_scaled, out_parse_ok);
          end
        end
      end
      if (beat_taken) begin
        step_byte(in_rx_byte);
        accepted_count++;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !beat_taken) begin
      // stalled beat stays as it is
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (byte_q.size() > 0) begin
      in_rx_byte <= byte_q.pop_front();
      in_valid   <= 1'b1;
      send_gap   = pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  initial begin
    int  round;
    int  n_frames;
    int  start_count;
    int  cut;
    bit  heavy;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_field("  123.45");
    queue_frame(8'h00, 8'hFF, 1'b1, FRAME_LEN);
    load_field("-0.00");
    queue_frame(text_byte(), text_byte(), 1'b0, FRAME_LEN);
    load_field("+.");
    queue_frame(text_byte(), text_byte(), 1'b1, FRAME_LEN);
    load_field("-");
    queue_frame(text_byte(), text_byte(), 1'b0, FRAME_LEN);
    load_field("abc");
    queue_frame(text_byte(), text_byte(), 1'b1, FRAME_LEN);
    load_field("9999999999");
    queue_frame(text_byte(), text_byte(), 1'b0, FRAME_LEN);
    load_field("-9999.9999");
    queue_frame(text_byte(), text_byte(), 1'b1, FRAME_LEN);
    load_field("\011\015\013\014 7.891");
    queue_frame(text_byte(), text_byte(), 1'b0, FRAME_LEN);
    load_field("12.34567e3");
    queue_frame(text_byte(), text_byte(), 1'b1, FRAME_LEN);
    load_field("0000000000");
    queue_frame(text_byte(), text_byte(), 1'b0, FRAME_LEN);
    load_field("1.2.3");
    queue_frame(text_byte(), text_byte(), 1'b1, FRAME_LEN);
    load_field("inf");
    queue_frame(text_byte(), text_byte(), 1'b0, FRAME_LEN);
    // newline inside the field, then inside the header
    queue_noise(6);
    queue_noise(1);
    load_field("5");
    queue_frame(text_byte(), text_byte(), 1'b0, FRAME_LEN);
    wait_idle();

    // three fraction digits taken, then the setting drops mid-frame
    write_fraction(3'd4);
    load_field("31.4159");
    queue_frame(text_byte(), text_byte(), 1'b0, 8);

    start_count = queued_count;
    round = 0;
    while (queued_count - start_count < RANDOM_ITEMS) begin
      wait_idle();
      write_fraction((round < 8) ? 3'((round * 5) % 8) : 3'($urandom_range(0, 7)));
      calm = (round % 4 == 3);
      while (carry_q.size() > 0) send(carry_q.pop_front());
      n_frames = $urandom_range(8, 16);
      for (int k = 0; k < n_frames; k++) begin
        if ($urandom_range(0, 9) < 2) begin
          queue_noise($urandom_range(0, FRAME_LEN - 1));
        end else begin
          field_pos = 0;
          heavy = ($urandom_range(0, 7) == 0);
          repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 4))
              0: put_field(CH_TAB);
              1: put_field(CH_CR);
              2: put_field(8'h0B);
              3: put_field(8'h0C);
              default: put_field(CH_SPACE);
            endcase
          end
          if ($urandom_range(0, 2) == 0) put_field($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
          repeat ($urandom_range(0, 7))
            put_field(heavy ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 1)) begin
            put_field(CH_POINT);
            repeat ($urandom_range(0, 6))
              put_field(heavy ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
          end
          while (field_pos < FIELD_LEN) put_field($urandom_range(0, 1) ? CH_SPACE : text_byte());
          cut = FRAME_LEN;
          if (k == n_frames - 1 && $urandom_range(0, 1)) cut = $urandom_range(1, FRAME_LEN - 1);
          queue_frame(text_byte(), text_byte(), 1'($urandom_range(0, 1)), cut);
        end
      end
      round++;
    end
    while (carry_q.size() > 0) send(carry_q.pop_front());
    wait_idle();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/sfwp_pkg.sv
src/sfwp_parse.sv
src/sfwp_emit.sv
src/scale_frame_weight_parser_top.sv
tb/testbench.sv
